// File: sv/fwss_pkg.sv
package fwss_pkg;

    // Field and datapath widths
    localparam int DATA_W = 24;   // Q15.8 ports and stored level
    localparam int NORM_W = 26;   // normalized speeds and mean target
    localparam int NUM_W  = 32;   // dividend of the shared divider
    localparam int DEN_W  = 6;    // divisor of the shared divider (up to 40)
    localparam int WHEELS = 4;
    localparam int MASK_W = 4;
    localparam int CNT_W  = 3;    // enabled wheel count, 0..4

    localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [NORM_W-1:0] t_norm;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic [DEN_W-1:0]         t_den;

    localparam t_data Q_MAX = 24'sh7FFFFF;
    localparam t_data Q_MIN = 24'sh800000;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_NORM,
        S_SUM,
        S_RNUM,
        S_LNUM,
        S_DNUM,
        S_DONE
    } t_state;

    // Which quotient the divider is working on
    typedef enum logic [1:0] {
        PH_AVG,
        PH_RAW,
        PH_LVL,
        PH_DRV
    } t_phase;

    // Saturate a wide value to the Q15.8 range
    function automatic t_data sat_data(input t_num v);
        t_data res;
        if (v > t_num'(Q_MAX)) begin
            res = Q_MAX;
        end else if (v < t_num'(Q_MIN)) begin
            res = Q_MIN;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: sv/fwss_div.sv
module fwss_div
    import fwss_pkg::*;
#(
    parameter int P_NUM_W = NUM_W,
    parameter int P_DEN_W = DEN_W
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [P_NUM_W-1:0] i_num,
    input  logic [P_DEN_W-1:0]        i_den,
    output logic                      o_done,
    output logic signed [P_NUM_W-1:0] o_quot
);

    // Two quotient bits per cycle
    localparam int ITERS = P_NUM_W / 2;
    localparam int ITW   = (ITERS > 1) ? $clog2(ITERS) : 1;

    logic [P_NUM_W-1:0] r_q, n_q;
    logic [P_DEN_W-1:0] r_r, n_r;
    logic [P_DEN_W-1:0] r_den;
    logic               r_neg;
    logic               r_busy;
    logic               r_done;
    logic [ITW-1:0]     r_cnt;
    logic [P_NUM_W:0]   start_mag;

    // Magnitude of the dividend plus half the divisor, for round-half-away
    always_comb begin
        logic [P_NUM_W:0] ext;
        logic [P_NUM_W:0] mag;
        ext = {i_num[P_NUM_W-1], i_num};
        mag = i_num[P_NUM_W-1] ? (~ext + 1'b1) : ext;
        start_mag = mag + (P_NUM_W+1)'(i_den >> 1);
    end

    // Two restoring steps of the long division
    always_comb begin
        logic [P_NUM_W-1:0] q;
        logic [P_DEN_W-1:0] rm;
        logic [P_DEN_W:0]   sh;
        logic [P_DEN_W:0]   diff;
        logic               ge;
        q  = r_q;
        rm = r_r;
        for (int k = 0; k < 2; k++) begin
            sh   = {rm, q[P_NUM_W-1]};
            diff = sh - {1'b0, r_den};
            ge   = (sh >= {1'b0, r_den});
            q    = {q[P_NUM_W-2:0], ge};
            rm   = ge ? diff[P_DEN_W-1:0] : sh[P_DEN_W-1:0];
        end
        n_q = q;
        n_r = rm;
    end

    // Control: load on start, iterate, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ITW'(ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend, remainder, sign
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= start_mag[P_NUM_W-1:0];
            r_r   <= '0;
            r_den <= i_den;
            r_neg <= i_num[P_NUM_W-1];
        end else if (r_busy) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_q + 1'b1) : r_q;

endmodule

// File: sv/four_wheel_speed_sync.sv
// Result computed with the shared rounding divider (two quotient bits a cycle): one division
// each for the mean target, the raw blend and the smoothed level, then one per enabled wheel.
// All-zero targets skip the divider. Throughput: one transaction at a time; the next is
// taken once the result has moved to the output register and the block is idle again.
// Reset (synchronous, active low): idle, no result pending, mask 15, smoothed level zero.
module four_wheel_speed_sync
    import fwss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MASK_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic signed [DATA_W-1:0] i_target_front_right,
    input  logic signed [DATA_W-1:0] i_target_front_left,
    input  logic signed [DATA_W-1:0] i_target_back_right,
    input  logic signed [DATA_W-1:0] i_target_back_left,
    input  logic signed [DATA_W-1:0] i_speed_front_right,
    input  logic signed [DATA_W-1:0] i_speed_front_left,
    input  logic signed [DATA_W-1:0] i_speed_back_right,
    input  logic signed [DATA_W-1:0] i_speed_back_left,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic signed [DATA_W-1:0] o_drive_front_right,
    output logic signed [DATA_W-1:0] o_drive_front_left,
    output logic signed [DATA_W-1:0] o_drive_back_right,
    output logic signed [DATA_W-1:0] o_drive_back_left
);

    // Control registers
    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [MASK_W-1:0] r_mask;
    logic              r_out_valid, n_out_valid;
    t_data             r_lvl, n_lvl;

    // Working registers
    t_data             r_tgt [WHEELS], n_tgt [WHEELS];
    t_data             r_spd [WHEELS], n_spd [WHEELS];
    t_norm             r_norm [WHEELS], n_norm [WHEELS];
    t_data             r_drive [WHEELS], n_drive [WHEELS];
    t_data             r_out [WHEELS], n_out [WHEELS];
    logic [MASK_W-1:0] r_en, n_en;
    logic [CNT_W-1:0]  r_n, n_n;
    t_norm             r_avg, n_avg;
    t_num              r_sum_n, n_sum_n;
    t_num              r_min_n, n_min_n;
    t_num              r_raw, n_raw;
    t_num              r_num, n_num;
    t_den              r_den, n_den;
    logic [1:0]        r_wheel, n_wheel;

    logic              div_start;
    logic              div_done;
    t_num              div_quot;

    logic              in_accept;
    logic              out_take;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;

    fwss_div #(
        .P_NUM_W(NUM_W),
        .P_DEN_W(DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // Sequencer: next state and datapath updates
    always_comb begin
        t_data       in_tgt [WHEELS];
        t_data       in_spd [WHEELS];
        t_num        sum_t;
        logic        all_zero;
        logic [CNT_W-1:0] cnt;
        t_num        s;
        t_num        m;
        logic        first;
        t_num        diff;
        t_num        n_ext;
        t_den        d_ext;

        in_tgt[0] = i_target_front_right;
        in_tgt[1] = i_target_front_left;
        in_tgt[2] = i_target_back_right;
        in_tgt[3] = i_target_back_left;
        in_spd[0] = i_speed_front_right;
        in_spd[1] = i_speed_front_left;
        in_spd[2] = i_speed_back_right;
        in_spd[3] = i_speed_back_left;

        n_state     = r_state;
        n_phase     = r_phase;
        n_out_valid = r_out_valid;
        n_lvl       = r_lvl;
        n_tgt       = r_tgt;
        n_spd       = r_spd;
        n_norm      = r_norm;
        n_drive     = r_drive;
        n_out       = r_out;
        n_en        = r_en;
        n_n         = r_n;
        n_avg       = r_avg;
        n_sum_n     = r_sum_n;
        n_min_n     = r_min_n;
        n_raw       = r_raw;
        n_num       = r_num;
        n_den       = r_den;
        n_wheel     = r_wheel;
        div_start   = 1'b0;
        o_in_stall  = (r_state != S_IDLE);

        // Drop the result once taken
        if (out_take) begin
            n_out_valid = 1'b0;
        end

        // Enabled target sum and count for the incoming transaction
        sum_t    = '0;
        all_zero = 1'b1;
        cnt      = '0;
        for (int i = 0; i < WHEELS; i++) begin
            if (in_tgt[i] != '0) begin
                all_zero = 1'b0;
            end
            if (r_mask[i]) begin
                sum_t = sum_t + t_num'(in_tgt[i]);
                cnt   = cnt + 1'b1;
            end
        end

        // Sum and minimum of the enabled normalized speeds
        s     = '0;
        m     = '0;
        first = 1'b1;
        for (int i = 0; i < WHEELS; i++) begin
            if (r_en[i]) begin
                s = s + t_num'(r_norm[i]);
                if (first || (t_num'(r_norm[i]) < m)) begin
                    m = t_num'(r_norm[i]);
                end
                first = 1'b0;
            end
        end

        n_ext = t_num'(r_n);
        d_ext = t_den'(r_n);
        diff  = t_num'(r_lvl) - t_num'(r_norm[r_wheel]);

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_tgt = in_tgt;
                    n_spd = in_spd;
                    n_en  = r_mask;
                    n_n   = cnt;
                    n_num = sum_t;
                    n_den = t_den'(cnt);
                    if (all_zero) begin
                        n_lvl = '0;
                        if (cnt != '0) begin
                            for (int i = 0; i < WHEELS; i++) begin
                                n_drive[i] = '0;
                            end
                            n_state = S_DONE;
                        end
                    end else if (cnt != '0) begin
                        n_phase = PH_AVG;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_DIV_GO: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    unique case (r_phase)
                        PH_AVG: begin
                            n_avg   = t_norm'(div_quot);
                            n_state = S_NORM;
                        end
                        PH_RAW: begin
                            n_raw   = div_quot;
                            n_state = S_LNUM;
                        end
                        PH_LVL: begin
                            n_lvl   = sat_data(div_quot);
                            n_wheel = '0;
                            n_state = S_DNUM;
                        end
                        PH_DRV: begin
                            n_drive[r_wheel] = sat_data(t_num'(r_tgt[r_wheel]) + div_quot);
                            if (r_wheel == 2'(WHEELS - 1)) begin
                                n_state = S_DONE;
                            end else begin
                                n_wheel = r_wheel + 1'b1;
                                n_state = S_DNUM;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_NORM: begin
                for (int i = 0; i < WHEELS; i++) begin
                    n_norm[i] = t_norm'(r_spd[i]) - t_norm'(r_tgt[i]) + r_avg;
                end
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum_n = s;
                n_min_n = m;
                n_state = S_RNUM;
            end
            S_RNUM: begin
                // 3*sum + 7*n*min over 10*n
                n_num   = (r_sum_n <<< 1) + r_sum_n + r_min_n * ((n_ext <<< 3) - n_ext);
                n_den   = (d_ext << 3) + (d_ext << 1);
                n_phase = PH_RAW;
                n_state = S_DIV_GO;
            end
            S_LNUM: begin
                // 8*level + 2*raw over 10
                n_num   = (t_num'(r_lvl) <<< 3) + (r_raw <<< 1);
                n_den   = t_den'(10);
                n_phase = PH_LVL;
                n_state = S_DIV_GO;
            end
            S_DNUM: begin
                if (r_en[r_wheel]) begin
                    // 6*(level - norm) over 10
                    n_num   = (diff <<< 2) + (diff <<< 1);
                    n_den   = t_den'(10);
                    n_phase = PH_DRV;
                    n_state = S_DIV_GO;
                end else begin
                    n_drive[r_wheel] = '0;
                    if (r_wheel == 2'(WHEELS - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_wheel = r_wheel + 1'b1;
                    end
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_drive;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_AVG;
            r_out_valid <= 1'b0;
            r_mask      <= MASK_RESET;
            r_lvl       <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_lvl       <= n_lvl;
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_tgt   <= n_tgt;
        r_spd   <= n_spd;
        r_norm  <= n_norm;
        r_drive <= n_drive;
        r_out   <= n_out;
        r_en    <= n_en;
        r_n     <= n_n;
        r_avg   <= n_avg;
        r_sum_n <= n_sum_n;
        r_min_n <= n_min_n;
        r_raw   <= n_raw;
        r_num   <= n_num;
        r_den   <= n_den;
        r_wheel <= n_wheel;
    end

    assign o_out_valid         = r_out_valid;
    assign o_drive_front_right = r_out[0];
    assign o_drive_front_left  = r_out[1];
    assign o_drive_back_right  = r_out[2];
    assign o_drive_back_left   = r_out[3];

endmodule

// File: tb/testbench.sv
module testbench;
    import fwss_pkg::*;

    localparam int SETTLE_CYCLES = 150;   // covers the longest computation
    localparam int HOLD_CYCLES   = 400;
    localparam int SEG_ITEMS     = 175;
    localparam int NOISE_ITEMS   = 12;
    localparam int NUM_SEGS      = 11;
    localparam int PHASE_LEN     = 583;
    localparam int Q_HI          = int'(Q_MAX);
    localparam int Q_LO          = int'(Q_MIN);

    // One input transaction and one result, wheel order FR, FL, BR, BL
    typedef struct {
        t_data target[WHEELS];
        t_data speed[WHEELS];
    } wheel_item_t;

    typedef struct {
        t_data drive[WHEELS];
    } drive_set_t;

    class sync_scoreboard;
        t_data             level;
        logic [MASK_W-1:0] mask;
        drive_set_t        expected_drives[$];
        int                errors;

        function new();
            level  = '0;
            mask   = MASK_RESET;
            errors = 0;
        endfunction

        function void set_mask(logic [MASK_W-1:0] m);
            mask = m;
        endfunction

        function int waiting();
            return expected_drives.size();
        endfunction

        // Divide with halves rounded away from zero; den is positive
        function longint div_nearest(longint num, longint den);
            if (num < 0) begin
                return -((-num + den / 2) / den);
            end
            return (num + den / 2) / den;
        endfunction

        function longint clamp_q(longint v);
            if (v > longint'(Q_MAX)) begin
                return longint'(Q_MAX);
            end
            if (v < longint'(Q_MIN)) begin
                return longint'(Q_MIN);
            end
            return v;
        endfunction

        function void report(string msg);
            // keep the log short when everything goes wrong
            if (errors < 100) begin
                $display("MISMATCH: %s", msg);
            end
            errors++;
        endfunction

        // Advance the smoothed level for one accepted transaction and queue its drives
        function void predict_drives(wheel_item_t item);
            longint     nrm[WHEELS];
            longint     cnt, sum_t, sum_n, min_n, avg_t, raw, lvl;
            bit         any_target, first;
            drive_set_t d;
            cnt        = 0;
            sum_t      = 0;
            sum_n      = 0;
            min_n      = 0;
            any_target = 1'b0;
            first      = 1'b1;
            for (int w = 0; w < WHEELS; w++) begin
                d.drive[w] = '0;
                nrm[w]     = 0;
                if (item.target[w] != '0) begin
                    any_target = 1'b1;
                end
                if (mask[w]) begin
                    cnt++;
                    sum_t += longint'(item.target[w]);
                end
            end

            // All targets zero: clear the level, zero drives unless the mask is empty
            if (!any_target) begin
                level = '0;
                if (cnt != 0) begin
                    expected_drives.push_back(d);
                end
                return;
            end
            if (cnt == 0) begin
                return;
            end

            // Normalize each enabled wheel against the mean target
            avg_t = div_nearest(sum_t, cnt);
            for (int w = 0; w < WHEELS; w++) begin
                if (mask[w]) begin
                    nrm[w] = longint'(item.speed[w]) - (longint'(item.target[w]) - avg_t);
                    sum_n += nrm[w];
                    if (first || nrm[w] < min_n) begin
                        min_n = nrm[w];
                    end
                    first = 1'b0;
                end
            end

            // Blend mean and minimum, then low-pass into the stored level
            raw   = div_nearest(3 * sum_n + 7 * cnt * min_n, 10 * cnt);
            lvl   = clamp_q(div_nearest(8 * longint'(level) + 2 * raw, 10));
            level = t_data'(lvl);

            for (int w = 0; w < WHEELS; w++) begin
                if (mask[w]) begin
                    d.drive[w] = t_data'(clamp_q(longint'(item.target[w])
                                                 + div_nearest(6 * (lvl - nrm[w]), 10)));
                end
            end
            expected_drives.push_back(d);
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_drives(drive_set_t got);
            drive_set_t exp_d;
            if (expected_drives.size() == 0) begin
                report("result with no transaction outstanding");
                return;
            end
            exp_d = expected_drives.pop_front();
            for (int w = 0; w < WHEELS; w++) begin
                if (got.drive[w] !== exp_d.drive[w]) begin
                    report($sformatf("wheel %0d drive got %0d expected %0d",
                                     w, got.drive[w], exp_d.drive[w]));
                end
            end
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [MASK_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_data             i_target_front_right = '0;
    t_data             i_target_front_left  = '0;
    t_data             i_target_back_right  = '0;
    t_data             i_target_back_left   = '0;
    t_data             i_speed_front_right  = '0;
    t_data             i_speed_front_left   = '0;
    t_data             i_speed_back_right   = '0;
    t_data             i_speed_back_left    = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_data             o_drive_front_right;
    t_data             o_drive_front_left;
    t_data             o_drive_back_right;
    t_data             o_drive_back_left;

    sync_scoreboard    sb = new();
    drive_set_t        seen_drives;
    int                send_idle_pct = 8;
    int                recv_idle_pct = 79;
    int                hold_left     = 0;
    bit                hold_req      = 1'b0;
    logic [MASK_W-1:0] seg_masks [NUM_SEGS] = '{4'hF, 4'h5, 4'h8, 4'h7, 4'h0, 4'hF,
                                                4'h2, 4'hB, 4'hE, 4'hF, 4'hA};

    four_wheel_speed_sync uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_target_front_right (i_target_front_right),
        .i_target_front_left  (i_target_front_left),
        .i_target_back_right  (i_target_back_right),
        .i_target_back_left   (i_target_back_left),
        .i_speed_front_right  (i_speed_front_right),
        .i_speed_front_left   (i_speed_front_left),
        .i_speed_back_right   (i_speed_back_right),
        .i_speed_back_left    (i_speed_back_left),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_drive_front_right  (o_drive_front_right),
        .o_drive_front_left   (o_drive_front_left),
        .o_drive_back_right   (o_drive_back_right),
        .o_drive_back_left    (o_drive_back_left)
    );

    always #5 i_clk = ~i_clk;

    // Check accepted results, then choose the next stall (long hold-offs take priority)
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_drives.drive[0] = o_drive_front_right;
            seen_drives.drive[1] = o_drive_front_left;
            seen_drives.drive[2] = o_drive_back_right;
            seen_drives.drive[3] = o_drive_back_left;
            sb.check_drives(seen_drives);
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic int rand_span(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_data extreme_value();
        case ($urandom_range(4))
            0: begin
                return Q_MAX;
            end
            1: begin
                return Q_MIN;
            end
            2: begin
                return '0;
            end
            3: begin
                return t_data'(-1);
            end
            default: begin
                return t_data'(1);
            end
        endcase
    endfunction

    function automatic wheel_item_t pack_item(int t0, int t1, int t2, int t3,
                                              int s0, int s1, int s2, int s3);
        wheel_item_t it;
        it.target = '{t_data'(t0), t_data'(t1), t_data'(t2), t_data'(t3)};
        it.speed  = '{t_data'(s0), t_data'(s1), t_data'(s2), t_data'(s3)};
        return it;
    endfunction

    // Mostly plausible driving: targets close together, speeds near their targets
    function automatic wheel_item_t random_item();
        wheel_item_t it;
        int          kind, base, dev;
        kind = $urandom_range(99);
        base = rand_span(1 << 20);
        dev  = $urandom_range(16384, 8);
        for (int w = 0; w < WHEELS; w++) begin
            if (kind < 3) begin
                it.target[w] = '0;
                it.speed[w]  = t_data'(rand_span(dev));
            end else if (kind < 10) begin
                it.target[w] = t_data'($urandom);
                it.speed[w]  = t_data'($urandom);
            end else if (kind < 15) begin
                it.target[w] = extreme_value();
                it.speed[w]  = extreme_value();
            end else begin
                it.target[w] = t_data'(base + rand_span(4096));
                it.speed[w]  = t_data'(int'(it.target[w]) + rand_span(dev));
            end
        end
        // drop one target to zero now and then, leaving the rest running
        if (kind >= 15 && $urandom_range(19) == 0) begin
            it.target[$urandom_range(WHEELS - 1)] = '0;
        end
        return it;
    endfunction

    // Offer one transaction, idling first at random, and hold it until accepted
    task automatic drive_item(wheel_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_target_front_right <= it.target[0];
        i_target_front_left  <= it.target[1];
        i_target_back_right  <= it.target[2];
        i_target_back_left   <= it.target[3];
        i_speed_front_right  <= it.speed[0];
        i_speed_front_left   <= it.speed[1];
        i_speed_back_right   <= it.speed[2];
        i_speed_back_left    <= it.speed[3];
        i_in_valid           <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.predict_drives(it);
    endtask

    // Wait for the block to go idle, then write the wheel mask
    task automatic write_mask(logic [MASK_W-1:0] m);
        i_in_valid <= 1'b0;
        while (sb.waiting() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_mask(m);
    endtask

    initial begin
        int counted;
        int n_items;
        counted = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero targets, saturation, slow wheel, mask corner cases
        drive_item(pack_item(0, 0, 0, 0, 1000, -2000, 3000, -4000));
        drive_item(pack_item(25600, 25600, 25600, 25600, 25600, 25600, 25600, 25600));
        drive_item(pack_item(25600, 25600, 25600, 25600, 25000, 25600, 26000, 25800));
        drive_item(pack_item(Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI));
        drive_item(pack_item(Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO));
        drive_item(pack_item(Q_HI, Q_LO, Q_HI, Q_LO, Q_LO, Q_HI, Q_LO, Q_HI));
        drive_item(pack_item(Q_LO, Q_HI, Q_LO, Q_HI, Q_HI, Q_LO, Q_HI, Q_LO));
        drive_item(pack_item(0, 12800, -12800, 6400, 100, 12000, -13000, 7000));
        drive_item(pack_item(1, -1, 1, -1, -1, 1, -1, 1));
        drive_item(pack_item(30000, 30000, 29000, 29000, 29500, 31000, 28000, 29900));
        // empty mask leaves the level alone...
        write_mask(4'h0);
        drive_item(pack_item(30000, 30000, 29000, 29000, 1, 2, 3, 4));
        write_mask(4'hF);
        drive_item(pack_item(30000, 30000, 29000, 29000, 29000, 30000, 28500, 29900));
        // ...except that zero targets still clear it
        write_mask(4'h0);
        drive_item(pack_item(0, 0, 0, 0, 700, 800, 900, 1000));
        write_mask(4'h1);
        drive_item(pack_item(5000, 0, 0, 0, 4000, Q_HI, Q_LO, 0));
        drive_item(pack_item(-5000, 7, 8, 9, -6000, 0, 0, 0));
        write_mask(4'h8);
        drive_item(pack_item(1, 2, 3, Q_LO, 0, 0, 0, Q_HI));
        write_mask(4'h6);
        drive_item(pack_item(0, 10000, -10000, 0, 0, 9000, -9500, 0));
        drive_item(pack_item(0, Q_HI, Q_LO, 0, 0, Q_LO, Q_HI, 0));
        write_mask(4'hB);
        drive_item(pack_item(20000, 21000, 0, 19000, 20500, 20000, 100, 19500));
        drive_item(pack_item(0, 0, 0, 0, 5, 5, 5, 5));

        // Random segments, one mask each; the empty-mask segment is noise only
        for (int s = 0; s < NUM_SEGS; s++) begin
            write_mask(seg_masks[s]);
            n_items = (seg_masks[s] == '0) ? NOISE_ITEMS : SEG_ITEMS;
            for (int k = 0; k < n_items; k++) begin
                if (seg_masks[s] != '0) begin
                    counted++;
                    if (counted == PHASE_LEN) begin
                        send_idle_pct = 79;
                        recv_idle_pct = 8;
                    end
                    if (counted == 2 * PHASE_LEN) begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                    // back the block up against a receiver that holds off
                    if (counted == 300 || counted == 1300) begin
                        hold_req = 1'b1;
                    end
                end
                drive_item(random_item());
            end
        end

        // Drain, then allow stray results to show up
        i_in_valid <= 1'b0;
        while (sb.waiting() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
sv/fwss_pkg.sv
sv/fwss_div.sv
sv/four_wheel_speed_sync.sv
tb/testbench.sv
